[rtl/core/pfl_pkg.sv]
package pfl_pkg;

   // defaults for the top-level parameters
   localparam int FRAMES_DEF   = 512;
   localparam int KEY_BITS_DEF = 40;

   // fixed field widths
   localparam int KEY_W      = 40;
   localparam int TOTAL_W    = 32;
   localparam int FCOUNT_W   = 10;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 112;
   localparam int RSP_PAD_W  = RSP_DATA_W - (2 + KEY_W + 2 * TOTAL_W);

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] REG_POLICY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FCOUNT = 1'b1;

   localparam logic [FCOUNT_W-1:0] FCOUNT_DEF = 10'd512;

   // replacement policy codes
   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU  = 1'b1;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // sequencer to top level: state of the current reference
   typedef struct packed {
      logic             idle;
      logic             done;
      logic             was_hit;
      logic             evict_valid;
      logic [KEY_W-1:0] evicted_key;
   } seq_res_type;

endpackage

[rtl/core/pfl_tag_store.sv]
module pfl_tag_store #(
   parameter int  FRAMES   = pfl_pkg::FRAMES_DEF,
   parameter int  KEY_BITS = pfl_pkg::KEY_BITS_DEF,
   localparam int ADDR_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [KEY_BITS-1:0] wr_tag,
   input  logic [ADDR_W-1:0]   rd_addr,
   input  logic [KEY_BITS-1:0] key,
   output logic [KEY_BITS-1:0] rd_tag,
   output logic                rd_match
);

   logic [KEY_BITS-1:0] mem [FRAMES];
   logic [KEY_BITS-1:0] rd_tag_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_tag;
      end
      rd_tag_ff <= mem[rd_addr];
   end

   // the shared tag comparator
   assign rd_tag   = rd_tag_ff;
   assign rd_match = (rd_tag_ff == key);

endmodule

[rtl/core/pfl_rank_store.sv]
module pfl_rank_store #(
   parameter int  FRAMES = pfl_pkg::FRAMES_DEF,
   localparam int ADDR_W = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [ADDR_W-1:0] wr_rank,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [ADDR_W-1:0] rd_rank
);

   logic [ADDR_W-1:0] mem [FRAMES];
   logic [ADDR_W-1:0] rd_rank_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_rank;
      end
      rd_rank_ff <= mem[rd_addr];
   end

   assign rd_rank = rd_rank_ff;

endmodule

[rtl/core/pfl_seq.sv]
module pfl_seq #(
   parameter int  FRAMES   = pfl_pkg::FRAMES_DEF,
   parameter int  KEY_BITS = pfl_pkg::KEY_BITS_DEF,
   localparam int ADDR_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1,
   localparam int CNT_W    = $clog2(FRAMES + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [KEY_BITS-1:0]  key,
   input  logic                 policy,
   input  logic [CNT_W-1:0]     limit,
   input  logic                 ack,
   output pfl_pkg::seq_res_type res,
   output logic [CNT_W-1:0]     occupancy
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]          state_ff,     state_in;
   logic [CNT_W-1:0]    idx_ff,       idx_in;
   logic                rd_vld_ff,    rd_vld_in;
   logic [ADDR_W-1:0]   rd_idx_ff,    rd_idx_in;
   logic [KEY_BITS-1:0] key_ff,       key_in;
   logic                hit_ff,       hit_in;
   logic [ADDR_W-1:0]   hit_slot_ff,  hit_slot_in;
   logic [ADDR_W-1:0]   hit_rank_ff,  hit_rank_in;
   logic                zero_ff,      zero_in;
   logic [ADDR_W-1:0]   zero_slot_ff, zero_slot_in;
   logic [KEY_BITS-1:0] zero_key_ff,  zero_key_in;
   logic [CNT_W-1:0]    occ_ff,       occ_in;
   logic [ADDR_W-1:0]   target_ff,    target_in;
   logic [ADDR_W-1:0]   pivot_ff,     pivot_in;
   logic                evict_ff,     evict_in;

   logic                tag_we;
   logic [ADDR_W-1:0]   tag_wa;
   logic                rank_we;
   logic [ADDR_W-1:0]   rank_wa;
   logic [ADDR_W-1:0]   rank_wd;
   logic [ADDR_W-1:0]   rd_addr;
   logic [KEY_BITS-1:0] rd_tag;
   logic                rd_match;
   logic [ADDR_W-1:0]   rd_rank;
   logic                more;
   logic [CNT_W-1:0]    occ_last;

   pfl_tag_store #(.FRAMES(FRAMES), .KEY_BITS(KEY_BITS)) u_tags (
      .clock    (clock),
      .wr_en    (tag_we),
      .wr_addr  (tag_wa),
      .wr_tag   (key_ff),
      .rd_addr  (rd_addr),
      .key      (key_ff),
      .rd_tag   (rd_tag),
      .rd_match (rd_match)
   );

   pfl_rank_store #(.FRAMES(FRAMES)) u_ranks (
      .clock   (clock),
      .wr_en   (rank_we),
      .wr_addr (rank_wa),
      .wr_rank (rank_wd),
      .rd_addr (rd_addr),
      .rd_rank (rd_rank)
   );

   // frames 0 .. occupancy-1 are the resident ones
   assign more     = (idx_ff < occ_ff);
   assign occ_last = occ_ff - CNT_W'(1);
   assign rd_addr  = idx_ff[ADDR_W-1:0];

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = idx_ff[ADDR_W-1:0];
      key_in       = key_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      hit_rank_in  = hit_rank_ff;
      zero_in      = zero_ff;
      zero_slot_in = zero_slot_ff;
      zero_key_in  = zero_key_ff;
      occ_in       = occ_ff;
      target_in    = target_ff;
      pivot_in     = pivot_ff;
      evict_in     = evict_ff;
      tag_we       = 1'b0;
      tag_wa       = zero_slot_ff;
      rank_we      = 1'b0;
      rank_wa      = rd_idx_ff;
      rank_wd      = rd_rank;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in   = key;
               hit_in   = 1'b0;
               zero_in  = 1'b0;
               evict_in = 1'b0;
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (more) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            rd_vld_in = more;
            if (rd_vld_ff) begin
               if (rd_match && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_slot_in = rd_idx_ff;
                  hit_rank_in = rd_rank;
               end
               if ((rd_rank == '0) && !zero_ff) begin
                  zero_in      = 1'b1;
                  zero_slot_in = rd_idx_ff;
                  zero_key_in  = rd_tag;
               end
            end
            if (!more && !rd_vld_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            idx_in = '0;
            if (hit_ff) begin
               target_in = hit_slot_ff;
               pivot_in  = hit_rank_ff;
               state_in  = (policy == pfl_pkg::POLICY_LRU) ? ST_UPDATE : ST_DONE;
            end else if ((occ_ff >= limit) && (occ_ff != '0)) begin
               // replace the oldest frame in place
               evict_in  = 1'b1;
               tag_we    = 1'b1;
               tag_wa    = zero_slot_ff;
               target_in = zero_slot_ff;
               pivot_in  = '0;
               state_in  = ST_UPDATE;
            end else begin
               tag_we   = 1'b1;
               tag_wa   = occ_ff[ADDR_W-1:0];
               rank_we  = 1'b1;
               rank_wa  = occ_ff[ADDR_W-1:0];
               rank_wd  = occ_ff[ADDR_W-1:0];
               occ_in   = occ_ff + CNT_W'(1);
               state_in = ST_DONE;
            end
         end
         ST_UPDATE: begin
            if (more) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            rd_vld_in = more;
            // move the target to newest, close the gap above the pivot
            if (rd_vld_ff) begin
               if (rd_idx_ff == target_ff) begin
                  rank_we = 1'b1;
                  rank_wd = occ_last[ADDR_W-1:0];
               end else if (rd_rank > pivot_ff) begin
                  rank_we = 1'b1;
                  rank_wd = rd_rank - ADDR_W'(1);
               end
            end
            if (!more && !rd_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         occ_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         occ_ff    <= occ_in;
         rd_vld_ff <= rd_vld_in;
      end
      idx_ff       <= idx_in;
      rd_idx_ff    <= rd_idx_in;
      key_ff       <= key_in;
      hit_ff       <= hit_in;
      hit_slot_ff  <= hit_slot_in;
      hit_rank_ff  <= hit_rank_in;
      zero_ff      <= zero_in;
      zero_slot_ff <= zero_slot_in;
      zero_key_ff  <= zero_key_in;
      target_ff    <= target_in;
      pivot_ff     <= pivot_in;
      evict_ff     <= evict_in;
   end

   always_comb begin
      res.idle        = (state_ff == ST_IDLE);
      res.done        = (state_ff == ST_DONE);
      res.was_hit     = hit_ff;
      res.evict_valid = evict_ff;
      res.evicted_key = evict_ff ? pfl_pkg::KEY_W'(zero_key_ff) : '0;
   end

   assign occupancy = occ_ff;

endmodule

[rtl/core/page_replacement_fifo_lru.sv]
// Page frame store with first-in first-out or least-recently-used replacement.
//
// req_ stream: one transfer carries one page reference (page key in tdata).
// rsp_ stream: one transfer per reference, carrying the hit flag, the evicted
// page (if any) and the running hit and miss totals.
// csr_ port: policy register at byte 0, frame limit at byte 4.
//
// Each reference is looked up by scanning the resident frames one per cycle
// through a single tag memory port and one comparator. A hit in
// least-recently-used mode, or a miss that evicts, adds a second pass over
// the rank memory. req_tready is high only between references.
// The result is held in an output register; while the receiver stalls it
// waits there, and the next finished result waits in the sequencer, which
// takes no new reference until that result is loaded. Reset empties the
// store at once (occupancy count to zero), clears both totals and sets the
// policy to first-in first-out and the limit to 512.
module page_replacement_fifo_lru #(
   parameter int FRAMES   = pfl_pkg::FRAMES_DEF,
   parameter int KEY_BITS = pfl_pkg::KEY_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // page_key [39:0]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [pfl_pkg::REQ_DATA_W-1:0]  req_tdata,
   // was_hit [0], evict_valid [1], evicted_key [41:2],
   // hit_total [73:42], miss_total [105:74], zero [111:106]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pfl_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pfl_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pfl_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pfl_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int CNT_W = $clog2(FRAMES + 1);
   localparam int LIM_W = (CNT_W > pfl_pkg::FCOUNT_W) ? CNT_W : pfl_pkg::FCOUNT_W;

   logic                              policy_ff,   policy_in;
   logic [pfl_pkg::FCOUNT_W-1:0]      fcount_ff,   fcount_in;
   logic [pfl_pkg::TOTAL_W-1:0]       hit_tot_ff,  hit_tot_in;
   logic [pfl_pkg::TOTAL_W-1:0]       miss_tot_ff, miss_tot_in;
   logic                              rsp_vld_ff,  rsp_vld_in;
   logic [pfl_pkg::RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   pfl_pkg::seq_res_type              seq_res;
   logic [CNT_W-1:0]                  occupancy;
   logic [CNT_W-1:0]                  limit;
   logic [LIM_W-1:0]                  fcount_ext;
   logic                              csr_wr;
   logic [pfl_pkg::CSR_IDX_W-1:0]     csr_idx;
   logic                              start;
   logic                              load;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[2];

   // take register writes as they come; software is to write only while idle, the block does not enforce it
   always_comb begin
      policy_in = policy_ff;
      fcount_in = fcount_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            pfl_pkg::REG_POLICY: policy_in = csr_pwdata[0];
            pfl_pkg::REG_FCOUNT: fcount_in = csr_pwdata[pfl_pkg::FCOUNT_W-1:0];
            default:             policy_in = policy_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         pfl_pkg::REG_POLICY: csr_prdata = pfl_pkg::CSR_DATA_W'(policy_ff);
         pfl_pkg::REG_FCOUNT: csr_prdata = pfl_pkg::CSR_DATA_W'(fcount_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // clamp the frame limit to 1 .. FRAMES
   assign fcount_ext = LIM_W'(fcount_ff);
   always_comb begin
      priority if (fcount_ext == '0) begin
         limit = CNT_W'(1);
      end else if (fcount_ext > LIM_W'(FRAMES)) begin
         limit = CNT_W'(FRAMES);
      end else begin
         limit = fcount_ext[CNT_W-1:0];
      end
   end

   assign req_tready = seq_res.idle;
   assign start      = req_tvalid && req_tready;

   // take the result once the output register is free or being drained
   assign load = seq_res.done && (!rsp_vld_ff || rsp_tready);

   pfl_seq #(.FRAMES(FRAMES), .KEY_BITS(KEY_BITS)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .key       (KEY_BITS'(req_tdata)),
      .policy    (policy_ff),
      .limit     (limit),
      .ack       (load),
      .res       (seq_res),
      .occupancy (occupancy)
   );

   // saturating totals, advanced as the result is loaded
   always_comb begin
      hit_tot_in  = hit_tot_ff;
      miss_tot_in = miss_tot_ff;
      if (load) begin
         if (seq_res.was_hit) begin
            if (hit_tot_ff != pfl_pkg::TOTAL_MAX) begin
               hit_tot_in = hit_tot_ff + pfl_pkg::TOTAL_W'(1);
            end
         end else if (miss_tot_ff != pfl_pkg::TOTAL_MAX) begin
            miss_tot_in = miss_tot_ff + pfl_pkg::TOTAL_W'(1);
         end
      end
   end

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (load) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = {{pfl_pkg::RSP_PAD_W{1'b0}}, miss_tot_in, hit_tot_in,
                        seq_res.evicted_key, seq_res.evict_valid, seq_res.was_hit};
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff   <= pfl_pkg::POLICY_FIFO;
         fcount_ff   <= pfl_pkg::FCOUNT_DEF;
         hit_tot_ff  <= '0;
         miss_tot_ff <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         policy_ff   <= policy_in;
         fcount_ff   <= fcount_in;
         hit_tot_ff  <= hit_tot_in;
         miss_tot_ff <= miss_tot_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // occupancy never runs past the store
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy <= CNT_W'(FRAMES))
      else $error("occupancy beyond frame store");

   // a hit never evicts
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (seq_res.done && seq_res.was_hit) |-> !seq_res.evict_valid)
      else $error("eviction reported on a hit");

   // no reference is taken the cycle after one is accepted
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      start |=> !req_tready)
      else $error("second reference taken while busy");

   // a new result appears only from a finished reference
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(seq_res.done))
      else $error("result without a finished reference");

endmodule

[tb/sv/page_replacement_fifo_lru_tb.sv]
`timescale 1ns / 100ps

module page_replacement_fifo_lru_tb;

   localparam int FRAMES      = pfl_pkg::FRAMES_DEF;
   // worst case: every reference at full occupancy (a scan and a second rank pass)
   // plus both idle draws, taken several times over
   localparam int CYCLE_LIMIT = 4_000_000;
   // a full second pass over the rank memory, with margin
   localparam int TAIL_CYCLES = 2 * FRAMES + 32;
   localparam int MAX_REPORTS = 60;
   localparam int KEY_POOL    = 48;
   localparam int MAX_IDLE    = 18;
   localparam int HOLD_CYCLES = 3000;
   localparam int STEP_MAX    = 32;
   localparam int PHASE_MAX   = 8;
   localparam int PEND_DEPTH  = 8;

   // one result transfer, laid out as on rsp_tdata from bit 0 up
   typedef struct packed {
      logic [pfl_pkg::TOTAL_W-1:0] miss_total;
      logic [pfl_pkg::TOTAL_W-1:0] hit_total;
      logic [pfl_pkg::KEY_W-1:0]   evicted_key;
      logic                        evict_valid;
      logic                        was_hit;
   } ref_result_type;

   // a row of the directed table: either a register write or a reference,
   // the latter optionally with its result typed in by hand
   typedef struct {
      bit                             is_cfg;
      logic [pfl_pkg::CSR_IDX_W-1:0]  reg_idx;
      logic [pfl_pkg::CSR_DATA_W-1:0] value;
      logic [pfl_pkg::KEY_W-1:0]      key;
      bit                             typed;
      ref_result_type                 res;
   } step_row_type;

   // one stretch of random references under a fixed register setting
   typedef struct {
      logic        policy;
      int unsigned fcount;
      int unsigned refs;
      int unsigned pool_hi;
      int unsigned holdoff;
   } phase_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [pfl_pkg::REQ_DATA_W-1:0]  req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [pfl_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [pfl_pkg::CSR_ADDR_W-1:0]  csr_paddr;
   logic [pfl_pkg::CSR_DATA_W-1:0]  csr_pwdata;
   logic [pfl_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                            csr_pready;

   // shadow copy of the frame store, advanced at every accepted reference
   logic [pfl_pkg::KEY_W-1:0]       shadow_tag   [FRAMES];
   bit                              shadow_valid [FRAMES];
   int unsigned                     shadow_rank  [FRAMES];
   int unsigned                     shadow_occ;
   logic [pfl_pkg::TOTAL_W-1:0]     shadow_hits;
   logic [pfl_pkg::TOTAL_W-1:0]     shadow_misses;
   logic                            shadow_policy;
   logic [pfl_pkg::FCOUNT_W-1:0]    shadow_fcount;

   // outstanding results in transfer order, as a small ring
   ref_result_type                  pend_res [PEND_DEPTH];
   int unsigned                     pend_wr;
   int unsigned                     pend_rd;
   step_row_type                    steps [STEP_MAX];
   int unsigned                     step_cnt;
   phase_type                       phases [PHASE_MAX];
   int unsigned                     phase_cnt;
   logic [pfl_pkg::KEY_W-1:0]       key_pool [KEY_POOL];

   bit                              req_idling;
   bit                              rsp_idling;
   int unsigned                     rsp_holdoff;
   int unsigned                     err_cnt;
   int unsigned                     report_cnt;
   int unsigned                     cycle_cnt;

   page_replacement_fifo_lru u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Shadow frame store
   // ------------------------------------------------------------------

   // Move every resident page ranked above the given rank down by one.
   function automatic void close_gap(int unsigned above);
      for (int i = 0; i < FRAMES; i++)
         if (shadow_valid[i] && shadow_rank[i] > above)
            shadow_rank[i]--;
   endfunction

   // Look the page up, place or promote it and return the result transfer
   // that the block owes for this reference.
   function automatic ref_result_type replace_page(logic [pfl_pkg::KEY_W-1:0] key);
      ref_result_type res;
      int             hit_slot;
      int             slot;
      int unsigned    lim;
      int unsigned    old_rank;
      res      = '0;
      hit_slot = -1;
      slot     = -1;
      // a limit of zero behaves as one, anything above the store as the store
      lim = 32'(shadow_fcount);
      if (lim < 1) lim = 1;
      if (lim > FRAMES) lim = FRAMES;

      for (int i = 0; i < FRAMES; i++)
         if (hit_slot < 0 && shadow_valid[i] && shadow_tag[i] == key)
            hit_slot = i;

      if (hit_slot >= 0) begin
         if (shadow_hits != pfl_pkg::TOTAL_MAX) shadow_hits++;
         // first-in first-out hits leave the ranks alone
         if (shadow_policy == pfl_pkg::POLICY_LRU && shadow_occ > 0) begin
            old_rank = shadow_rank[hit_slot];
            close_gap(old_rank);
            shadow_rank[hit_slot] = shadow_occ - 1;
         end
      end else begin
         if (shadow_misses != pfl_pkg::TOTAL_MAX) shadow_misses++;
         // full, or limit lowered below occupancy: evict exactly one page
         if (shadow_occ >= lim && shadow_occ > 0) begin
            for (int i = 0; i < FRAMES; i++)
               if (slot < 0 && shadow_valid[i] && shadow_rank[i] == 0)
                  slot = i;
            if (slot >= 0) begin
               res.evict_valid   = 1'b1;
               res.evicted_key   = shadow_tag[slot];
               shadow_valid[slot] = 1'b0;
               close_gap(0);
               shadow_occ--;
            end
         end
         if (slot < 0)
            for (int i = 0; i < FRAMES; i++)
               if (slot < 0 && !shadow_valid[i])
                  slot = i;
         if (slot >= 0) begin
            shadow_tag[slot]   = key;
            shadow_valid[slot] = 1'b1;
            shadow_rank[slot]  = shadow_occ;
            shadow_occ++;
         end
      end

      res.was_hit    = (hit_slot >= 0);
      res.hit_total  = shadow_hits;
      res.miss_total = shadow_misses;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Table builders and small helpers
   // ------------------------------------------------------------------

   function automatic step_row_type cfg_row(logic [pfl_pkg::CSR_IDX_W-1:0] idx,
                                            logic [pfl_pkg::CSR_DATA_W-1:0] val);
      step_row_type row;
      row         = '{default: '0};
      row.is_cfg  = 1'b1;
      row.reg_idx = idx;
      row.value   = val;
      return row;
   endfunction

   function automatic step_row_type ref_row(logic [pfl_pkg::KEY_W-1:0] key);
      step_row_type row;
      row     = '{default: '0};
      row.key = key;
      return row;
   endfunction

   // reference whose result is plain enough to type in
   function automatic step_row_type ref_row_exp(logic [pfl_pkg::KEY_W-1:0] key,
                                                logic hit, logic ev,
                                                logic [pfl_pkg::KEY_W-1:0] ev_key,
                                                int unsigned hits,
                                                int unsigned misses);
      step_row_type row;
      row                 = ref_row(key);
      row.typed           = 1'b1;
      row.res.was_hit     = hit;
      row.res.evict_valid = ev;
      row.res.evicted_key = ev_key;
      row.res.hit_total   = hits;
      row.res.miss_total  = misses;
      return row;
   endfunction

   function automatic phase_type phase_row(logic policy, int unsigned fcount,
                                           int unsigned refs, int unsigned pool_hi,
                                           int unsigned holdoff);
      phase_type ph;
      ph.policy  = policy;
      ph.fcount  = fcount;
      ph.refs    = refs;
      ph.pool_hi = pool_hi;
      ph.holdoff = holdoff;
      return ph;
   endfunction

   function automatic void add_step(step_row_type row);
      steps[step_cnt] = row;
      step_cnt++;
   endfunction

   function automatic void add_phase(phase_type ph);
      phases[phase_cnt] = ph;
      phase_cnt++;
   endfunction

   function automatic void pend_add(ref_result_type res);
      pend_res[pend_wr % PEND_DEPTH] = res;
      pend_wr++;
   endfunction

   function automatic ref_result_type pend_take();
      ref_result_type res;
      res = pend_res[pend_rd % PEND_DEPTH];
      pend_rd++;
      return res;
   endfunction

   function automatic int unsigned pend_count();
      return pend_wr - pend_rd;
   endfunction

   function automatic logic [pfl_pkg::KEY_W-1:0] fresh_key();
      logic [7:0]  top;
      logic [31:0] low;
      top = 8'($urandom_range(0, 255));
      low = $urandom();
      return {top, low};
   endfunction

   function automatic void check_field(string name, logic [63:0] want,
                                       logic [63:0] got);
      if (got !== want) begin
         err_cnt++;
         // keep the log short when the block is badly off
         if (report_cnt < MAX_REPORTS) begin
            report_cnt++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Offer one reference after a drawn gap and hold it until the transfer.
   // valid stays high afterwards so that a zero gap runs back to back; the
   // caller drops it in the same step when no reference follows.
   task automatic send_ref(logic [pfl_pkg::KEY_W-1:0] key, bit typed,
                           ref_result_type typed_res);
      int unsigned    gap;
      ref_result_type predicted;
      gap = req_idling ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      do @(posedge clock); while (!req_tready);
      predicted = replace_page(key);
      pend_add(typed ? typed_res : predicted);
   endtask

   // Setup cycle, then access cycle until pready; then a wait with psel low, so
   // that back-to-back writes never raise and drop psel in the same step.
   task automatic write_csr(logic [pfl_pkg::CSR_IDX_W-1:0] idx,
                            logic [pfl_pkg::CSR_DATA_W-1:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == pfl_pkg::REG_POLICY)
         shadow_policy = val[0];
      else
         shadow_fcount = val[pfl_pkg::FCOUNT_W-1:0];
      @(posedge clock);
   endtask

   // Hold until every outstanding result has been transferred.
   task automatic wait_drained();
      while (pend_count() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;

      foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
      shadow_occ    = 0;
      shadow_hits   = '0;
      shadow_misses = '0;
      shadow_policy = pfl_pkg::POLICY_FIFO;
      shadow_fcount = pfl_pkg::FCOUNT_DEF;
      pend_wr       = 0;
      pend_rd       = 0;
      step_cnt      = 0;
      phase_cnt     = 0;
      err_cnt       = 0;
      report_cnt    = 0;
      rsp_holdoff   = 0;
      req_idling    = 1'b1;
      rsp_idling    = 1'b1;
      foreach (key_pool[i]) key_pool[i] = fresh_key();

      // Out of reset: first-in first-out, limit 512, store empty.
      add_step(ref_row_exp(40'h00_0000_0000, 1'b0, 1'b0, '0, 0, 1));
      add_step(ref_row_exp(40'hFF_FFFF_FFFF, 1'b0, 1'b0, '0, 0, 2));
      add_step(ref_row_exp(40'h00_0000_0000, 1'b1, 1'b0, '0, 1, 2));
      add_step(ref_row_exp(40'h55_5555_5555, 1'b0, 1'b0, '0, 1, 3));
      add_step(ref_row_exp(40'hAA_AAAA_AAAA, 1'b0, 1'b0, '0, 1, 4));
      // limit lowered below occupancy: each miss swaps out the oldest page,
      // the first one being the all-zero key itself
      add_step(cfg_row(pfl_pkg::REG_FCOUNT, 32'd2));
      add_step(ref_row_exp(40'h12_3456_789A, 1'b0, 1'b1, 40'h00_0000_0000, 1, 5));
      // first-in first-out hit: ranks stay put, so all-ones goes next
      add_step(ref_row_exp(40'hFF_FFFF_FFFF, 1'b1, 1'b0, '0, 2, 5));
      add_step(ref_row_exp(40'h00_0000_0000, 1'b0, 1'b1, 40'hFF_FFFF_FFFF, 2, 6));
      // switch policy with the ranks as they stand
      add_step(cfg_row(pfl_pkg::REG_POLICY,
                       pfl_pkg::CSR_DATA_W'(pfl_pkg::POLICY_LRU)));
      add_step(ref_row(40'h55_5555_5555));
      add_step(ref_row(40'hFE_DCBA_9876));
      add_step(ref_row(40'h12_3456_789A));
      add_step(ref_row(40'h00_0000_0000));
      // a limit of zero behaves as a single frame
      add_step(cfg_row(pfl_pkg::REG_FCOUNT, 32'd0));
      add_step(ref_row(40'h80_0000_0000));
      add_step(ref_row(40'h00_0000_0001));
      add_step(ref_row(40'h00_0000_0001));
      // a limit above the store behaves as the whole store
      add_step(cfg_row(pfl_pkg::REG_FCOUNT, 32'd1023));
      add_step(cfg_row(pfl_pkg::REG_POLICY,
                       pfl_pkg::CSR_DATA_W'(pfl_pkg::POLICY_FIFO)));
      add_step(ref_row(40'h01_0203_0405));
      add_step(ref_row(40'h01_0203_0405));
      add_step(ref_row(40'hFF_FFFF_FFFE));
      add_step(ref_row(40'h7F_FFFF_FFFF));

      // Random phases. Occupancy never shrinks, so all small limits come before
      // the wide settings, which come only at the end. In the small-limit phases the pool
      // bound keeps the working set a little above the limit so that hits and evictions mix.
      add_phase(phase_row(pfl_pkg::POLICY_LRU,  1,    60, 9,  0));
      add_phase(phase_row(pfl_pkg::POLICY_FIFO, 3,    70, 5,  0));
      add_phase(phase_row(pfl_pkg::POLICY_LRU,  8,    70, 11, HOLD_CYCLES));
      add_phase(phase_row(pfl_pkg::POLICY_FIFO, 0,    50, 3,  0));
      add_phase(phase_row(pfl_pkg::POLICY_LRU,  16,   80, 23, 0));
      add_phase(phase_row(pfl_pkg::POLICY_FIFO, 12,   70, 17, 0));
      add_phase(phase_row(pfl_pkg::POLICY_LRU,  512,  90, 47, 0));
      add_phase(phase_row(pfl_pkg::POLICY_FIFO, 1023, 90, 47, 0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < step_cnt; i++) begin
         if (steps[i].is_cfg) begin
            // registers change only with the block idle
            req_tvalid <= 1'b0;
            wait_drained();
            write_csr(steps[i].reg_idx, steps[i].value);
         end else begin
            send_ref(steps[i].key, steps[i].typed, steps[i].res);
         end
      end

      for (int p = 0; p < phase_cnt; p++) begin
         req_tvalid <= 1'b0;
         wait_drained();
         write_csr(pfl_pkg::REG_POLICY, pfl_pkg::CSR_DATA_W'(phases[p].policy));
         write_csr(pfl_pkg::REG_FCOUNT, pfl_pkg::CSR_DATA_W'(phases[p].fcount));
         // leave two sender phases and three receiver phases without any idling
         req_idling  = (p % 4 != 3);
         rsp_idling  = (p % 3 != 1);
         // long receiver hold-off: the output register fills and req stalls
         rsp_holdoff = phases[p].holdoff;
         for (int n = 0; n < phases[p].refs; n++) begin
            if ($urandom_range(0, 3) == 0)
               send_ref(fresh_key(), 1'b0, '0);
            else
               send_ref(key_pool[$urandom_range(0, phases[p].pool_hi)], 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      wait_drained();
      // let any stray result surface before the verdict
      repeat (TAIL_CYCLES) @(posedge clock);

      if (err_cnt == 0)
         $display("[page_replacement_fifo_lru] OK");
      else
         $display("[page_replacement_fifo_lru] ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // Result side: drawn stalls, then compare each transfer with the oldest
   // outstanding expectation
   // ------------------------------------------------------------------

   initial begin
      int unsigned    stall;
      ref_result_type want;
      ref_result_type got;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_holdoff != 0) begin
            stall       = rsp_holdoff;
            rsp_holdoff = 0;
         end else begin
            stall = rsp_idling ? $urandom_range(0, MAX_IDLE) : 0;
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);

         got = rsp_tdata[pfl_pkg::RSP_DATA_W-pfl_pkg::RSP_PAD_W-1:0];
         if (pend_count() == 0) begin
            err_cnt++;
            if (report_cnt < MAX_REPORTS) begin
               report_cnt++;
               $display("%0t: unexpected result, expected none, actual %0h",
                        $time, rsp_tdata);
            end
         end else begin
            want = pend_take();
            check_field("was_hit",     64'(want.was_hit),     64'(got.was_hit));
            check_field("evict_valid", 64'(want.evict_valid), 64'(got.evict_valid));
            check_field("evicted_key", 64'(want.evicted_key), 64'(got.evicted_key));
            check_field("hit_total",   64'(want.hit_total),   64'(got.hit_total));
            check_field("miss_total",  64'(want.miss_total),  64'(got.miss_total));
            check_field("padding",     64'(0),
                        64'(rsp_tdata[pfl_pkg::RSP_DATA_W-1 -: pfl_pkg::RSP_PAD_W]));
         end
      end
   end

   // Watchdog: end the run if the block stops answering.
   initial begin
      cycle_cnt = 0;
      while (cycle_cnt < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("[page_replacement_fifo_lru] ERROR");
      $finish;
   end

endmodule

[files.f]
rtl/core/pfl_pkg.sv
rtl/core/pfl_tag_store.sv
rtl/core/pfl_rank_store.sv
rtl/core/pfl_seq.sv
rtl/core/page_replacement_fifo_lru.sv
tb/sv/page_replacement_fifo_lru_tb.sv
